>>> rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants and helpers for the axis-angle rotation matrix core.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int AXIS_W  = 16;
  localparam int OUT_W   = 18;
  localparam int CORD_W  = 34;
  localparam int CORD_FB = 30;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic [31:0] atan_lut(input int unsigned i);
    logic [31:0] r;
    begin
      unique case (i)
        0:  r = 32'h20000000; 1:  r = 32'h12E4051E; 2:  r = 32'h09FB385B;
        3:  r = 32'h051111D4; 4:  r = 32'h028B0D43; 5:  r = 32'h0145D7E1;
        6:  r = 32'h00A2F61E; 7:  r = 32'h00517C55; 8:  r = 32'h0028BE53;
        9:  r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
        15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
        21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
        24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
        27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
        30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [47:0] v);
    logic signed [OUT_W-1:0] r;
    begin
      if (v > 48'sd131071) r = 18'sd131071;
      else if (v < -48'sd131072) r = -18'sd131072;
      else r = v[OUT_W-1:0];
      return r;
    end
  endfunction

endpackage

>>> rtl/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// Unrolled CORDIC rotation pipeline, one register stage per step, with the
// axis carried alongside. Emits quadrant-corrected cosine and sine.
// ----------------------------------------------------------------------------
module aarm_cordic #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_v,
  input  logic [15:0]                          angle,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   ax_i,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   ay_i,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   az_i,
  output logic                                 out_v,
  output logic signed [FRAC_BITS+1:0]          c_o,
  output logic signed [FRAC_BITS+1:0]          s_o,
  output logic signed [aarm_pkg::AXIS_W-1:0]   ax_o,
  output logic signed [aarm_pkg::AXIS_W-1:0]   ay_o,
  output logic signed [aarm_pkg::AXIS_W-1:0]   az_o
);
  import aarm_pkg::*;

  localparam int N  = CORDIC_STAGES;
  localparam int SH = CORD_FB - FRAC_BITS;

  logic                     v_r  [N+1];
  logic signed [CORD_W-1:0] x_r  [N+1];
  logic signed [CORD_W-1:0] y_r  [N+1];
  logic signed [CORD_W-1:0] z_r  [N+1];
  logic [1:0]               q_r  [N+1];
  logic signed [AXIS_W-1:0] ax_r [N+1];
  logic signed [AXIS_W-1:0] ay_r [N+1];
  logic signed [AXIS_W-1:0] az_r [N+1];

  logic [ANGLE_WIDTH-1:0] ang;
  logic [31:0]            zin;

  assign ang = ANGLE_WIDTH'({16'd0, angle});
  assign zin = {2'b00, ang[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= in_v;
    if (adv) begin
      x_r[0]  <= CORDIC_GAIN;
      y_r[0]  <= '0;
      z_r[0]  <= CORD_W'({2'b00, zin});
      q_r[0]  <= ang[ANGLE_WIDTH-1 -: 2];
      ax_r[0] <= ax_i;
      ay_r[0] <= ay_i;
      az_r[0] <= az_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CORD_W-1:0] dx, dy, at;
    assign dx = x_r[i] >>> ((i < 32) ? i : 31);
    assign dy = y_r[i] >>> ((i < 32) ? i : 31);
    assign at = CORD_W'(atan_lut(i % 32));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (adv) v_r[i+1] <= v_r[i];
      if (adv) begin
        if (!z_r[i][CORD_W-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + at;
        end
        q_r[i+1]  <= q_r[i];
        ax_r[i+1] <= ax_r[i];
        ay_r[i+1] <= ay_r[i];
        az_r[i+1] <= az_r[i];
      end
    end
  end

  logic signed [CORD_W-1:0] cq, sq;
  logic signed [CORD_W-1:0] cr, sr;
  logic signed [CORD_W-1:0] one_w;

  always_comb begin
    unique case (q_r[N])
      2'd0:    begin cq = x_r[N];  sq = y_r[N];  end
      2'd1:    begin cq = -y_r[N]; sq = x_r[N];  end
      2'd2:    begin cq = -x_r[N]; sq = -y_r[N]; end
      default: begin cq = y_r[N];  sq = -x_r[N]; end
    endcase
    one_w = CORD_W'(1) <<< FRAC_BITS;
    cr = (cq + (CORD_W'(1) <<< (SH - 1))) >>> SH;
    sr = (sq + (CORD_W'(1) <<< (SH - 1))) >>> SH;
    if (cr > one_w) cr = one_w;
    if (cr < -one_w) cr = -one_w;
    if (sr > one_w) sr = one_w;
    if (sr < -one_w) sr = -one_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0;
    else if (adv) out_v <= v_r[N];
    if (adv) begin
      c_o  <= cr[FRAC_BITS+1:0];
      s_o  <= sr[FRAC_BITS+1:0];
      ax_o <= ax_r[N];
      ay_o <= ay_r[N];
      az_o <= az_r[N];
    end
  end

endmodule

>>> rtl/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// Three-stage product pipeline: t*a and a*s, then t*a*b, then sums with
// saturation into the output register.
// ----------------------------------------------------------------------------
module aarm_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_v,
  input  logic signed [FRAC_BITS+1:0]          c_i,
  input  logic signed [FRAC_BITS+1:0]          s_i,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   ax_i,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   ay_i,
  input  logic signed [aarm_pkg::AXIS_W-1:0]   az_i,
  output logic                                 out_v,
  output logic signed [aarm_pkg::OUT_W-1:0]    m_o [9]
);
  import aarm_pkg::*;

  localparam int PW = 48;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    return (v + HALF) >>> FRAC_BITS;
  endfunction

  // stage 1
  logic                     v1_r;
  logic signed [PW-1:0]     tx_r, ty_r, tz_r, xs_r, ys_r, zs_r;
  logic signed [FRAC_BITS+1:0] c1_r;
  logic signed [AXIS_W-1:0] ax1_r, ay1_r, az1_r;
  logic signed [FRAC_BITS+2:0] t_w;

  assign t_w = (FRAC_BITS+3)'(1) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_v;
    if (adv) begin
      tx_r  <= rnd(PW'(t_w - c_i) * PW'(ax_i));
      ty_r  <= rnd(PW'(t_w - c_i) * PW'(ay_i));
      tz_r  <= rnd(PW'(t_w - c_i) * PW'(az_i));
      xs_r  <= rnd(PW'(ax_i) * PW'(s_i));
      ys_r  <= rnd(PW'(ay_i) * PW'(s_i));
      zs_r  <= rnd(PW'(az_i) * PW'(s_i));
      c1_r  <= c_i;
      ax1_r <= ax_i;
      ay1_r <= ay_i;
      az1_r <= az_i;
    end
  end

  // stage 2
  logic                 v2_r;
  logic signed [PW-1:0] txx_r, tyy_r, tzz_r, txy_r, tzx_r, tyz_r;
  logic signed [PW-1:0] xs2_r, ys2_r, zs2_r, c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      txx_r <= rnd(tx_r * PW'(ax1_r));
      tyy_r <= rnd(ty_r * PW'(ay1_r));
      tzz_r <= rnd(tz_r * PW'(az1_r));
      txy_r <= rnd(tx_r * PW'(ay1_r));
      tzx_r <= rnd(tz_r * PW'(ax1_r));
      tyz_r <= rnd(ty_r * PW'(az1_r));
      xs2_r <= xs_r;
      ys2_r <= ys_r;
      zs2_r <= zs_r;
      c2_r  <= PW'(c1_r);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0;
    else if (adv) out_v <= v2_r;
    if (adv) begin
      m_o[0] <= sat_out(txx_r + c2_r);
      m_o[1] <= sat_out(txy_r + zs2_r);
      m_o[2] <= sat_out(tzx_r - ys2_r);
      m_o[3] <= sat_out(txy_r - zs2_r);
      m_o[4] <= sat_out(tyy_r + c2_r);
      m_o[5] <= sat_out(tyz_r + xs2_r);
      m_o[6] <= sat_out(tzx_r + ys2_r);
      m_o[7] <= sat_out(tyz_r - xs2_r);
      m_o[8] <= sat_out(tzz_r + c2_r);
    end
  end

endmodule

>>> rtl/axis_angle_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Axis-angle to 3x3 rotation matrix: CORDIC sine/cosine then Rodrigues terms.
// ----------------------------------------------------------------------------
// channel | ports                        | direction
// in      | in_valid/in_stall, angle+axis| into core
// out     | out_valid/out_stall, r0c0..  | out of core
//
// One word accepted per cycle while the output word is not stalled.
// Throughput is set by the fully unrolled CORDIC and product pipeline.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline holds while a valid output word is stalled.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        in_angle,
  input  logic signed [aarm_pkg::AXIS_W-1:0] in_axis_x,
  input  logic signed [aarm_pkg::AXIS_W-1:0] in_axis_y,
  input  logic signed [aarm_pkg::AXIS_W-1:0] in_axis_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r0c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r0c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r0c2,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r1c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r1c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r1c2,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r2c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r2c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_r2c2
);
  import aarm_pkg::*;

  logic                        adv, cv;
  logic signed [FRAC_BITS+1:0] c, s;
  logic signed [AXIS_W-1:0]    ax, ay, az;
  logic signed [OUT_W-1:0]     m [9];

  // advance unless the output word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  aarm_cordic #(
    .ANGLE_WIDTH(ANGLE_WIDTH), .FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_valid), .angle(in_angle),
    .ax_i(in_axis_x), .ay_i(in_axis_y), .az_i(in_axis_z),
    .out_v(cv), .c_o(c), .s_o(s), .ax_o(ax), .ay_o(ay), .az_o(az)
  );

  aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(cv), .c_i(c), .s_i(s),
    .ax_i(ax), .ay_i(ay), .az_i(az), .out_v(out_valid), .m_o(m)
  );

  assign out_r0c0 = m[0];
  assign out_r0c1 = m[1];
  assign out_r0c2 = m[2];
  assign out_r1c0 = m[3];
  assign out_r1c1 = m[4];
  assign out_r1c2 = m[5];
  assign out_r2c0 = m[6];
  assign out_r2c1 = m[7];
  assign out_r2c2 = m[8];

endmodule

>>> rtl/aarm_checker.sv
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks for the rotation matrix core.
// ----------------------------------------------------------------------------
module aarm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_r0c0,
  input logic [17:0] out_r1c1
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r0c0) && $stable(out_r1c1))
    else $error("output word changed while held");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_r0c0(out_r0c0), .out_r1c1(out_r1c1)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the axis-angle rotation matrix core: an internal predictor computes
// the CORDIC sine/cosine and the nine Rodrigues entries for every accepted
// word, and a scoreboard compares them with the output words in order.
// ----------------------------------------------------------------------------
module tb;
  import aarm_pkg::*;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] ax, ay, az;
  } rot_req_t;

  typedef logic signed [OUT_W-1:0] entry_t;
  typedef struct packed {
    entry_t e0, e1, e2, e3, e4, e5, e6, e7, e8;
  } rot_mat_t;

  localparam int LATENCY   = 16 + 5;
  localparam int STALL_MAX = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_angle = '0;
  logic signed [15:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  entry_t out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2;
  entry_t out_r2c0, out_r2c1, out_r2c2;

  axis_angle_rotation_matrix_core uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rot_req_t pending_words[$];
  rot_mat_t expected_mats[$];
  int       send_idle_pct = 0, recv_stall_pct = 0;
  int       hold_off_cycles = 0;
  int       errors = 0, words_sent = 0, words_checked = 0;
  int       quiet_cycles = 0;
  bit       stim_done = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v);
    return floor_shr(v + (64'sd1 <<< 13), 14);
  endfunction

  function automatic longint cordic_to_q14(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic entry_t clamp18(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return entry_t'(v);
  endfunction

  function automatic rot_mat_t rodrigues_matrix(rot_req_t w);
    longint x, y, z, dx, dy, c, s, t, ax, ay, az;
    longint txx, tyy, tzz, txy, tzx, tyz, xs, ys, zs;
    logic [1:0] quad;
    rot_mat_t m;
    quad = w.angle[15:14];
    z = longint'({w.angle[13:0], 16'h0});
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = cordic_to_q14(c);
    s = cordic_to_q14(s);
    t = 16384 - c;
    ax = w.ax; ay = w.ay; az = w.az;
    txx = round_q(round_q(t * ax) * ax);
    tyy = round_q(round_q(t * ay) * ay);
    tzz = round_q(round_q(t * az) * az);
    txy = round_q(round_q(t * ax) * ay);
    tzx = round_q(round_q(t * az) * ax);
    tyz = round_q(round_q(t * ay) * az);
    xs = round_q(ax * s);
    ys = round_q(ay * s);
    zs = round_q(az * s);
    m.e0 = clamp18(txx + c); m.e1 = clamp18(txy + zs); m.e2 = clamp18(tzx - ys);
    m.e3 = clamp18(txy - zs); m.e4 = clamp18(tyy + c); m.e5 = clamp18(tyz + xs);
    m.e6 = clamp18(tzx + ys); m.e7 = clamp18(tyz - xs); m.e8 = clamp18(tzz + c);
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_mats.push_back(rodrigues_matrix({in_angle, in_axis_x, in_axis_y,
                                                  in_axis_z}));
        words_sent++;
      end
      if ((!in_valid || !in_stall) && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        rot_req_t w;
        w = pending_words.pop_front();
        in_valid  <= 1'b1;
        in_angle  <= w.angle;
        in_axis_x <= w.ax;
        in_axis_y <= w.ay;
        in_axis_z <= w.az;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_mat_t got, exp_m;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
             out_r2c0, out_r2c1, out_r2c2};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_m = expected_mats.pop_front();
        words_checked++;
        for (int k = 0; k < 9; k++)
          if (got[(8-k)*OUT_W +: OUT_W] !== exp_m[(8-k)*OUT_W +: OUT_W]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                     $signed(exp_m[(8-k)*OUT_W +: OUT_W]),
                     $signed(got[(8-k)*OUT_W +: OUT_W]));
            errors++;
          end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else if (pending_words.size() > 0 || expected_mats.size() > 0 || in_valid)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16384));
      2: return -16'($urandom_range(16384));
      default: return 16'($urandom_range(32767, 0) - 16384);
    endcase
  endfunction

  task automatic queue_word(logic [15:0] a, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
    pending_words.push_back({a, x, y, z});
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_mats.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, quadrant edges, unnormalised axes
    queue_word(16'h0000, 16'sd16384, 16'sd0, 16'sd0);
    queue_word(16'h4000, 16'sd0, 16'sd16384, 16'sd0);
    queue_word(16'h8000, 16'sd0, 16'sd0, 16'sd16384);
    queue_word(16'hC000, 16'sd9459, 16'sd9459, 16'sd9459);
    queue_word(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_word(16'h3FFF, 16'h8000, 16'h8000, 16'h8000);
    queue_word(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    queue_word(16'hBFFF, 16'h8000, 16'h7FFF, 16'h0000);
    queue_word(16'h0001, 16'hFFFF, 16'h0001, 16'h8000);
    queue_word(16'h2000, 16'h0000, 16'h0000, 16'h0000);
    queue_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    queue_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_word(16'hE000, 16'h7FFF, 16'h8000, 16'h8000);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int i = 0; i < 125; i++)
        queue_word(16'($urandom), rand_axis(), rand_axis(), rand_axis());
      if (p == 0) begin
        repeat (3) @(posedge clk);
        hold_off_cycles = 200;
      end
      drain();
    end
    stim_done = 1;
    $display("Sent %0d angle/axis words, checked %0d matrices", words_sent,
             words_checked);
    $display("Phases: no idling, sender gaps, receiver stalls, both, long hold-off");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
